// ===== rtl/lab_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the look-at basis pipeline
package lab_pkg;

    // input field width (positions Q8.8, up vector Q1.14)
    localparam int IN_FW = 16;

    // normalize unit: input width, normalized magnitude, square sum, root
    localparam int VN_IN_W   = 50;
    localparam int VN_M_W    = 30;
    localparam int VN_SQ_W   = 62;
    localparam int VN_ROOT_W = 31;
    localparam int VN_Q_W    = 31;
    localparam int VN_O_W    = 32;
    localparam int VN_P_W    = 6;
    localparam int NORM_MSB  = 29;

    // normalize unit latency: 5 front stages, root steps, divide steps, sign
    localparam int VN_LAT = 5 + VN_ROOT_W + VN_Q_W + 1;

    // fixed-point constants
    localparam logic signed [31:0] NUDGE_Q30 = 32'sd107374;
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

endpackage

// ===== rtl/lab_vnorm.sv =====
`timescale 1ns / 1ps
// Vector normalize to Q2.30: scale, sum of squares, root, three dividers
module lab_vnorm #(
    parameter int SIDE_W = 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   vld_in,
    input  logic signed [lab_pkg::VN_IN_W-1:0]     v_in [3],
    input  logic        [SIDE_W-1:0]               side_in,
    output logic                                   vld_out,
    output logic signed [lab_pkg::VN_O_W-1:0]      u_out [3],
    output logic        [SIDE_W-1:0]               side_out
);
    localparam int IW    = lab_pkg::VN_IN_W;
    localparam int MW    = lab_pkg::VN_M_W;
    localparam int SW    = lab_pkg::VN_SQ_W;
    localparam int RW    = lab_pkg::VN_ROOT_W;
    localparam int QW    = lab_pkg::VN_Q_W;
    localparam int OW    = lab_pkg::VN_O_W;
    localparam int PW    = lab_pkg::VN_P_W;
    localparam int LAT   = lab_pkg::VN_LAT;
    localparam int REM_W = RW + 3;

    // valid and sideband delay line
    logic [LAT-1:0]    vld_reg;
    logic [SIDE_W-1:0] side_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign vld_out  = vld_reg[LAT-1];
    assign side_out = side_reg[LAT-1];

    // stage 1: magnitudes and signs
    logic [IW-1:0] mag1_reg [3];
    logic [2:0]    neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= v_in[i][IW-1];
                mag1_reg[i] <= v_in[i][IW-1] ? ($unsigned(~v_in[i]) + 1'b1)
                                             : $unsigned(v_in[i]);
            end
        end
    end

    // stage 2: leading one of the largest magnitude
    logic [IW-1:0] orv;
    logic [PW-1:0] pos_c;
    logic [IW-1:0] mag2_reg [3];
    logic [2:0]    neg2_reg;
    logic [PW-1:0] pos2_reg;
    logic          zero2_reg;

    always_comb
    begin
        orv   = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        pos_c = '0;
        for (int b = 0; b < IW; b++)
            if (orv[b])
                pos_c = PW'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            pos2_reg  <= pos_c;
            zero2_reg <= (orv == '0);
        end
    end

    // stage 3: shift so the largest magnitude lands in [2^29, 2^30)
    logic [IW-1:0] sh_c [3];
    logic [MW-1:0] m3_reg [3];
    logic [2:0]    neg3_reg;
    logic          zero3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos2_reg > PW'(lab_pkg::NORM_MSB))
                sh_c[i] = mag2_reg[i] >> (pos2_reg - PW'(lab_pkg::NORM_MSB));
            else
                sh_c[i] = mag2_reg[i] << (PW'(lab_pkg::NORM_MSB) - pos2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                m3_reg[i] <= sh_c[i][MW-1:0];
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // stage 4: squares
    logic [2*MW-1:0] sq4_reg [3];
    logic [MW-1:0]   m4_reg [3];
    logic [2:0]      neg4_reg;
    logic            zero4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= m3_reg[i] * m3_reg[i];
            m4_reg    <= m3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5 and root steps: index 0 holds the sum of squares
    logic [SW-1:0]    sn_reg    [RW+1];
    logic [REM_W-1:0] srem_reg  [RW+1];
    logic [RW-1:0]    sroot_reg [RW+1];
    logic [MW-1:0]    sm_reg    [RW+1][3];
    logic [2:0]       sneg_reg  [RW+1];
    logic             szero_reg [RW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg[0]    <= SW'(sq4_reg[0]) + SW'(sq4_reg[1]) + SW'(sq4_reg[2]);
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            sm_reg[0]    <= m4_reg;
            sneg_reg[0]  <= neg4_reg;
            szero_reg[0] <= zero4_reg;
        end
    end

    // one root digit per stage, two radicand bits at a time
    for (genvar k = 0; k < RW; k++)
    begin : g_root
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] test;
        logic             ge;

        always_comb
        begin
            trial = {srem_reg[k][REM_W-3:0], sn_reg[k][SW-1-2*k -: 2]};
            test  = {1'b0, sroot_reg[k], 2'b01};
            ge    = (trial >= test);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[k+1]  <= ge ? (trial - test) : trial;
                sroot_reg[k+1] <= {sroot_reg[k][RW-2:0], ge};
                sn_reg[k+1]    <= sn_reg[k];
                sm_reg[k+1]    <= sm_reg[k];
                sneg_reg[k+1]  <= sneg_reg[k];
                szero_reg[k+1] <= szero_reg[k];
            end
        end
    end

    // divide steps: quotient of (m << 30) by the length, one bit per stage
    logic [RW-1:0] drem_reg  [QW][3];
    logic [QW-1:0] dq_reg    [QW][3];
    logic [RW-1:0] dlen_reg  [QW];
    logic [2:0]    dneg_reg  [QW];
    logic          dzero_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [RW-1:0] p_rem [3];
        logic [QW-1:0] p_q [3];
        logic [2:0]    p_bit;
        logic [RW-1:0] p_len;
        logic [2:0]    p_neg;
        logic          p_zero;
        logic [RW:0]   trial [3];
        logic [2:0]    ge;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_rem[i] = {2'b00, sm_reg[RW][i][MW-1:1]};
                    p_q[i]   = '0;
                    p_bit[i] = sm_reg[RW][i][0];
                end
                p_len  = sroot_reg[RW];
                p_neg  = sneg_reg[RW];
                p_zero = szero_reg[RW];
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_rem[i] = drem_reg[j-1][i];
                    p_q[i]   = dq_reg[j-1][i];
                    p_bit[i] = 1'b0;
                end
                p_len  = dlen_reg[j-1];
                p_neg  = dneg_reg[j-1];
                p_zero = dzero_reg[j-1];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {p_rem[i], p_bit[i]};
                ge[i]    = (trial[i] >= {1'b0, p_len});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[j][i] <= ge[i] ? RW'(trial[i] - {1'b0, p_len})
                                            : trial[i][RW-1:0];
                    dq_reg[j][i]   <= {p_q[i][QW-2:0], ge[i]};
                end
                dlen_reg[j]  <= p_len;
                dneg_reg[j]  <= p_neg;
                dzero_reg[j] <= p_zero;
            end
        end
    end

    // final stage: restore signs, zero vector gives zero
    logic signed [OW-1:0] u_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dzero_reg[QW-1])
                    u_reg[i] <= '0;
                else if (dneg_reg[QW-1][i])
                    u_reg[i] <= -OW'(dq_reg[QW-1][i]);
                else
                    u_reg[i] <= OW'(dq_reg[QW-1][i]);
            end
        end
    end

    assign u_out = u_reg;

endmodule

// ===== rtl/lab_cross.sv =====
`timescale 1ns / 1ps
// Cross product a x b: products, then differences
module lab_cross #(
    parameter int A_W    = 16,
    parameter int B_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld_in,
    input  logic signed [A_W-1:0]     a [3],
    input  logic signed [B_W-1:0]     b [3],
    input  logic        [SIDE_W-1:0]  side_in,
    output logic                      vld_out,
    output logic signed [A_W+B_W:0]   c_out [3],
    output logic        [SIDE_W-1:0]  side_out
);
    localparam int P_W = A_W + B_W;

    logic [1:0]            vld_reg;
    logic [SIDE_W-1:0]     side_reg [2];
    logic signed [P_W-1:0] p_reg [6];
    logic signed [P_W:0]   c_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], vld_in};
    end

    // products, then pairwise differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            p_reg[0] <= a[1] * b[2];
            p_reg[1] <= a[2] * b[1];
            p_reg[2] <= a[2] * b[0];
            p_reg[3] <= a[0] * b[2];
            p_reg[4] <= a[0] * b[1];
            p_reg[5] <= a[1] * b[0];
            c_reg[0] <= (P_W+1)'(p_reg[0]) - (P_W+1)'(p_reg[1]);
            c_reg[1] <= (P_W+1)'(p_reg[2]) - (P_W+1)'(p_reg[3]);
            c_reg[2] <= (P_W+1)'(p_reg[4]) - (P_W+1)'(p_reg[5]);
        end
    end

    assign vld_out  = vld_reg[1];
    assign side_out = side_reg[1];
    assign c_out    = c_reg;

endmodule

// ===== rtl/look_at_basis_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Signals                          Contents
// s_axis   in   tvalid tready tdata[143:0]       eye, target, world up
// m_axis   out  tvalid tready tdata tuser[0]     right, camera up, forward axes
//
// One request per cycle while the output is not stalled; the pipeline holds three normalize units
// in series, each a 31-step square root followed by 31-step dividers.
// rst_n clears all valid bits asynchronously; payload is not reset.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module look_at_basis_core #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [143:0]                            s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // right_x, right_y, right_z, camup_x, camup_y, camup_z, fwd_x, fwd_y, fwd_z
    output logic [((9*COMP_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // degenerate
    output logic                                    m_axis_tuser
);
    localparam int OUT_W = ((9*COMP_WIDTH+7)/8)*8;
    localparam int FW    = lab_pkg::IN_FW;
    localparam int OW    = lab_pkg::VN_O_W;
    localparam int IW    = lab_pkg::VN_IN_W;
    localparam int XC_W  = FW + OW + 1;
    localparam int Y_W   = 2*OW + 1;
    localparam int S30   = 32 - COMP_WIDTH;
    localparam int S60   = 62 - COMP_WIDTH;
    localparam int RM_W  = 34;
    localparam logic [RM_W-1:0] HALF30 = (34'd1 << S30) >> 1;
    localparam logic [Y_W:0]    HALF60 = (66'd1 << S60) >> 1;
    localparam logic [RM_W-1:0] LIM_NEG = 34'd1 << (COMP_WIDTH-1);
    localparam logic [RM_W-1:0] LIM_POS = LIM_NEG - 34'd1;

    localparam int SIDE1_W = 3*FW + 1;
    localparam int SIDE2_W = 3*FW + 3*OW + 1;
    localparam int SIDE3_W = 3*FW + 3*OW + 2;
    localparam int SIDE4_W = 3*OW + 1;
    localparam int SIDE5_W = 6*OW + 1;

    // global advance: the output register is free or being emptied
    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // input stage: differences and degenerate check
    logic signed [FW-1:0] eye_c [3];
    logic signed [FW-1:0] tgt_c [3];
    logic signed [FW-1:0] upv_c [3];
    logic                 p0_vld_reg;
    logic signed [FW:0]   d0_reg [3];
    logic signed [FW-1:0] up0_reg [3];
    logic                 degen0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_c[i] = s_axis_tdata[FW*i +: FW];
            tgt_c[i] = s_axis_tdata[FW*(3+i) +: FW];
            upv_c[i] = s_axis_tdata[FW*(6+i) +: FW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_vld_reg <= 1'b0;
        else if (en)
            p0_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d0_reg[i]  <= (FW+1)'(eye_c[i]) - (FW+1)'(tgt_c[i]);
                up0_reg[i] <= upv_c[i];
            end
            degen0_reg <= (eye_c[0] == tgt_c[0]) && (eye_c[1] == tgt_c[1])
                          && (eye_c[2] == tgt_c[2]);
        end
    end

    // forward axis: normalize eye minus target
    logic signed [IW-1:0] n1_v [3];
    logic                 n1_vld;
    logic signed [OW-1:0] z1 [3];
    logic [SIDE1_W-1:0]   n1_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_v[i] = IW'(d0_reg[i]);
    end

    lab_vnorm #(.SIDE_W(SIDE1_W)) u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (p0_vld_reg),
        .v_in     (n1_v),
        .side_in  ({degen0_reg, up0_reg[2], up0_reg[1], up0_reg[0]}),
        .vld_out  (n1_vld),
        .u_out    (z1),
        .side_out (n1_side)
    );

    // up x forward
    logic signed [FW-1:0]   up1 [3];
    logic                   c1_vld;
    logic signed [XC_W-1:0] xc1 [3];
    logic [SIDE2_W-1:0]     c1_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            up1[i] = n1_side[FW*i +: FW];
    end

    lab_cross #(.A_W(FW), .B_W(OW), .SIDE_W(SIDE2_W)) u_cross_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (n1_vld),
        .a        (up1),
        .b        (z1),
        .side_in  ({n1_side[3*FW], z1[2], z1[1], z1[0], n1_side[3*FW-1:0]}),
        .vld_out  (c1_vld),
        .c_out    (xc1),
        .side_out (c1_side)
    );

    // nudge forward when up and forward are parallel
    logic                 c1_zero;
    logic                 c1_onez;
    logic signed [FW-1:0] c1_upz;
    logic signed [OW-1:0] c1_z [3];
    logic                 nz_vld_reg;
    logic signed [OW-1:0] zn_reg [3];
    logic [SIDE3_W-1:0]   nz_side_reg;

    always_comb
    begin
        c1_zero = (xc1[0] == '0) && (xc1[1] == '0) && (xc1[2] == '0);
        c1_upz  = c1_side[2*FW +: FW];
        c1_onez = (c1_upz == lab_pkg::ONE_Q14) || (c1_upz == -lab_pkg::ONE_Q14);
        for (int i = 0; i < 3; i++)
            c1_z[i] = c1_side[3*FW + OW*i +: OW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nz_vld_reg <= 1'b0;
        else if (en)
            nz_vld_reg <= c1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zn_reg[0] <= c1_z[0] + ((c1_zero && c1_onez) ? lab_pkg::NUDGE_Q30 : '0);
            zn_reg[1] <= c1_z[1];
            zn_reg[2] <= c1_z[2] + ((c1_zero && !c1_onez) ? lab_pkg::NUDGE_Q30 : '0);
            nz_side_reg <= {c1_side[SIDE2_W-1], c1_zero, c1_side[SIDE2_W-2:0]};
        end
    end

    // renormalize the nudged forward axis
    logic signed [IW-1:0] n2_v [3];
    logic                 n2_vld;
    logic signed [OW-1:0] z2 [3];
    logic [SIDE3_W-1:0]   n2_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n2_v[i] = IW'(zn_reg[i]);
    end

    lab_vnorm #(.SIDE_W(SIDE3_W)) u_norm_nudge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (nz_vld_reg),
        .v_in     (n2_v),
        .side_in  (nz_side_reg),
        .vld_out  (n2_vld),
        .u_out    (z2),
        .side_out (n2_side)
    );

    // final forward axis, then up x forward again
    logic signed [FW-1:0]   up2 [3];
    logic signed [OW-1:0]   zf2 [3];
    logic                   c2_vld;
    logic signed [XC_W-1:0] xf [3];
    logic [SIDE4_W-1:0]     c2_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up2[i] = n2_side[FW*i +: FW];
            zf2[i] = n2_side[3*FW + 3*OW] ? z2[i] : n2_side[3*FW + OW*i +: OW];
        end
    end

    lab_cross #(.A_W(FW), .B_W(OW), .SIDE_W(SIDE4_W)) u_cross_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (n2_vld),
        .a        (up2),
        .b        (zf2),
        .side_in  ({n2_side[SIDE3_W-1], zf2[2], zf2[1], zf2[0]}),
        .vld_out  (c2_vld),
        .c_out    (xf),
        .side_out (c2_side)
    );

    // right axis: normalize the cross product
    logic signed [IW-1:0] n3_v [3];
    logic                 n3_vld;
    logic signed [OW-1:0] x3 [3];
    logic [SIDE4_W-1:0]   n3_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n3_v[i] = IW'(xf[i]);
    end

    lab_vnorm #(.SIDE_W(SIDE4_W)) u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (c2_vld),
        .v_in     (n3_v),
        .side_in  (c2_side),
        .vld_out  (n3_vld),
        .u_out    (x3),
        .side_out (n3_side)
    );

    // camera up: forward x right
    logic signed [OW-1:0]  zf3 [3];
    logic                  c3_vld;
    logic signed [Y_W-1:0] y3 [3];
    logic [SIDE5_W-1:0]    c3_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            zf3[i] = n3_side[OW*i +: OW];
    end

    lab_cross #(.A_W(OW), .B_W(OW), .SIDE_W(SIDE5_W)) u_cross_camup (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (n3_vld),
        .a        (zf3),
        .b        (x3),
        .side_in  ({n3_side[3*OW], n3_side[3*OW-1:0], x3[2], x3[1], x3[0]}),
        .vld_out  (c3_vld),
        .c_out    (y3),
        .side_out (c3_side)
    );

    // rounding stage: magnitudes rounded half away from zero
    logic [OW-1:0]   rx_mag [3];
    logic [OW-1:0]   rz_mag [3];
    logic [Y_W-1:0]  ry_mag [3];
    logic signed [OW-1:0] rx_v [3];
    logic signed [OW-1:0] rz_v [3];
    logic [Y_W:0]    ry_sum [3];
    logic [Y_W:0]    ry_shr [3];
    logic [RM_W-1:0] rnd_next [9];
    logic [8:0]      neg_next;
    logic            rnd_vld_reg;
    logic [RM_W-1:0] rnd_mag_reg [9];
    logic [8:0]      rnd_neg_reg;
    logic            rnd_degen_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rx_v[i]   = c3_side[OW*i +: OW];
            rz_v[i]   = c3_side[3*OW + OW*i +: OW];
            rx_mag[i] = rx_v[i][OW-1] ? ($unsigned(~rx_v[i]) + 1'b1) : $unsigned(rx_v[i]);
            rz_mag[i] = rz_v[i][OW-1] ? ($unsigned(~rz_v[i]) + 1'b1) : $unsigned(rz_v[i]);
            ry_mag[i] = y3[i][Y_W-1] ? ($unsigned(~y3[i]) + 1'b1) : $unsigned(y3[i]);
            ry_sum[i] = (Y_W+1)'(ry_mag[i]) + HALF60;
            ry_shr[i] = ry_sum[i] >> S60;
            rnd_next[i]   = (RM_W'(rx_mag[i]) + HALF30) >> S30;
            rnd_next[3+i] = ry_shr[i][RM_W-1:0];
            rnd_next[6+i] = (RM_W'(rz_mag[i]) + HALF30) >> S30;
            neg_next[i]   = rx_v[i][OW-1];
            neg_next[3+i] = y3[i][Y_W-1];
            neg_next[6+i] = rz_v[i][OW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_vld_reg <= 1'b0;
        else if (en)
            rnd_vld_reg <= c3_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_mag_reg   <= rnd_next;
            rnd_neg_reg   <= neg_next;
            rnd_degen_reg <= c3_side[SIDE5_W-1];
        end
    end

    // saturate to the signed output range
    function automatic logic [COMP_WIDTH-1:0] sat_fn(input logic [RM_W-1:0] mag,
                                                     input logic neg);
        logic [RM_W-1:0]       neg_mag;
        logic [COMP_WIDTH-1:0] r;
        neg_mag = ~mag + 34'd1;
        if (neg)
            r = (mag > LIM_NEG) ? LIM_NEG[COMP_WIDTH-1:0] : neg_mag[COMP_WIDTH-1:0];
        else
            r = (mag > LIM_POS) ? LIM_POS[COMP_WIDTH-1:0] : mag[COMP_WIDTH-1:0];
        return r;
    endfunction

    // output register
    logic [COMP_WIDTH-1:0] out_fld_reg [9];
    logic                  out_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= rnd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
                out_fld_reg[i] <= rnd_degen_reg ? '0 : sat_fn(rnd_mag_reg[i], rnd_neg_reg[i]);
            out_degen_reg <= rnd_degen_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_degen_reg;

    for (genvar i = 0; i < 9; i++)
    begin : g_pack
        assign m_axis_tdata[COMP_WIDTH*i +: COMP_WIDTH] = out_fld_reg[i];
    end

    if (OUT_W > 9*COMP_WIDTH)
    begin : g_pad
        assign m_axis_tdata[OUT_W-1:9*COMP_WIDTH] = '0;
    end

endmodule

// ===== dv/look_at_basis_core_tb.sv =====
`timescale 1ns / 1ps
module look_at_basis_core_tb;

    localparam int CW = 16;
    localparam int OW = ((9 * CW + 7) / 8) * 8;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OW-1:0] axes;
        logic          degen;
    } basis_t;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [143:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [OW-1:0] m_axis_tdata;
    logic          m_axis_tuser;

    logic [143:0] pending_req[$];
    basis_t       expected_basis[$];
    int           errors;
    longint       cycles;
    bit           stim_done;
    int           send_wait;
    int           recv_wait;
    int           long_hold;
    int           accepted;
    bit           in_taken;
    string        fld_name [9] = '{"right_x", "right_y", "right_z",
                                   "camup_x", "camup_y", "camup_z",
                                   "fwd_x", "fwd_y", "fwd_z"};

    look_at_basis_core #(.COMP_WIDTH(CW)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #10 clk = ~clk;

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector in Q2.30; zero stays zero
    function automatic void unit_q30(input longint v[3], output longint o[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0)
        begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return;
        end
        while (mx >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] << 30) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // round half away from zero, then saturate to CW bits
    function automatic logic [CW-1:0] round_sat(input longint v, input int s);
        logic [63:0] m;
        longint r;
        longint hi;
        longint lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -(longint'(1) << (CW - 1));
        m = v < 0 ? 64'(-v) : 64'(v);
        if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;
        if (m > (64'd1 << 40)) m = 64'd1 << 40;
        r = v < 0 ? -longint'(m) : longint'(m);
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[CW-1:0];
    endfunction

    function automatic basis_t camera_basis(input logic [143:0] req);
        longint d[3], up[3], z[3], zn[3], x[3], xc[3], y[3];
        basis_t b;
        b.axes = '0;
        b.degen = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'($signed(req[16*i +: 16])) - longint'($signed(req[16*(3+i) +: 16]));
            up[i] = longint'($signed(req[16*(6+i) +: 16]));
        end
        if (d[0] == 0 && d[1] == 0 && d[2] == 0)
        begin
            b.degen = 1'b1;
            return b;
        end
        unit_q30(d, z);
        cross3(up, z, xc);
        if (xc[0] == 0 && xc[1] == 0 && xc[2] == 0)
        begin
            if (up[2] == 16384 || up[2] == -16384) z[0] += 107374;
            else z[2] += 107374;
            unit_q30(z, zn);
            z = zn;
            cross3(up, z, xc);
        end
        unit_q30(xc, x);
        cross3(z, x, y);
        for (int i = 0; i < 3; i++)
        begin
            b.axes[CW*i +: CW] = round_sat(x[i], 32 - CW);
            b.axes[CW*(3+i) +: CW] = round_sat(y[i], 62 - CW);
            b.axes[CW*(6+i) +: CW] = round_sat(z[i], 32 - CW);
        end
        return b;
    endfunction

    function automatic logic [143:0] pack_req(input logic [15:0] f[9]);
        logic [143:0] r;
        for (int i = 0; i < 9; i++) r[16*i +: 16] = f[i];
        return r;
    endfunction

    // stimulus: directed corners, then mostly ordinary scenes plus parallel/degenerate cases
    initial
    begin
        logic [15:0] f[9];
        int kind;
        // extremes
        f = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
              16'h7fff, 16'h8000, 16'h7fff};
        pending_req.push_back(pack_req(f));
        f = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h8000, 16'h7fff, 16'h8000};
        pending_req.push_back(pack_req(f));
        // eye equals target
        f = '{16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300, 0, 16384, 0};
        pending_req.push_back(pack_req(f));
        f = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
        pending_req.push_back(pack_req(f));
        // ordinary camera
        f = '{0, 0, 16'h0500, 0, 0, 0, 0, 16384, 0};
        pending_req.push_back(pack_req(f));
        // up parallel to forward, z unit up: nudge on x
        f = '{0, 0, 16'h0100, 0, 0, 0, 0, 0, 16384};
        pending_req.push_back(pack_req(f));
        f = '{0, 0, 16'hff00, 0, 0, 0, 0, 0, 16'(-16384)};
        pending_req.push_back(pack_req(f));
        // up parallel along y: nudge on z
        f = '{0, 16'h0300, 0, 0, 0, 0, 0, 16384, 0};
        pending_req.push_back(pack_req(f));
        f = '{0, 16'h0300, 0, 0, 0, 0, 0, 16'h8000, 0};
        pending_req.push_back(pack_req(f));
        // parallel, not unit
        f = '{16'h0200, 16'h0200, 16'h0200, 0, 0, 0, 100, 100, 100};
        pending_req.push_back(pack_req(f));
        // zero up vector
        f = '{16'h0123, 16'h0456, 16'h0789, 0, 0, 0, 0, 0, 0};
        pending_req.push_back(pack_req(f));
        // tiny offset
        f = '{1, 0, 0, 0, 0, 0, 0, 16384, 0};
        pending_req.push_back(pack_req(f));
        f = '{0, 0, 16'hffff, 0, 0, 0, 16384, 0, 0};
        pending_req.push_back(pack_req(f));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++) f[i] = 16'($urandom);
            if (kind < 2)
            begin
                // small coordinates, unit-ish up
                for (int i = 0; i < 6; i++) f[i] = 16'($signed(10'($urandom)));
                f[6 + $urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'd16384 : 16'(-16384);
            end
            else if (kind == 2)
            begin
                for (int i = 0; i < 3; i++) f[3 + i] = f[i];
            end
            else if (kind == 3)
            begin
                // up parallel to eye - target, target at origin
                int a;
                int k;
                a = $urandom_range(0, 2);
                k = $urandom_range(1, 64);
                for (int i = 0; i < 9; i++) f[i] = 0;
                f[a] = 16'($urandom_range(1, 2000));
                if ($urandom_range(0, 1)) f[a] = -f[a];
                f[6 + a] = $urandom_range(0, 1) ? 16'd16384 : 16'(k * 100);
            end
            else if (kind == 4)
            begin
                for (int i = 6; i < 9; i++) f[i] = 0;
            end
            pending_req.push_back(pack_req(f));
        end
        stim_done = 1'b1;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        cycles = 0;
        send_wait = 0;
        recv_wait = 0;
        long_hold = 0;
        accepted = 0;
        in_taken = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // request acceptance: predict at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_basis.push_back(camera_basis(s_axis_tdata));
            accepted <= accepted + 1;
            in_taken <= 1'b1;
        end
        else
            in_taken <= 1'b0;
    end

    // request driver: load the next item after a random gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (send_wait > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_req.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_req.pop_front();
                    send_wait <= (accepted % 400 < 100) ? 0 : $urandom_range(0, 5);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink ready: random stalls, plus one long hold-off to back the pipe up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (accepted == 500 && long_hold == 0)
            begin
                long_hold <= 600;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold > 1)
            begin
                long_hold <= long_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                if (long_hold == 1) long_hold <= -1;
                recv_wait <= recv_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (long_hold == 1) long_hold <= -1;
                m_axis_tready <= 1'b1;
                recv_wait <= (accepted % 500 < 120) ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        basis_t exp_b;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_basis.size() == 0)
            begin
                $error("unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_b = expected_basis.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[CW*i +: CW] !== exp_b.axes[CW*i +: CW])
                    begin
                        $error("%s: exp %h got %h",
                               fld_name[i], exp_b.axes[CW*i +: CW], m_axis_tdata[CW*i +: CW]);
                        errors++;
                    end
                if ((m_axis_tdata >> (9*CW)) !== (exp_b.axes >> (9*CW)))
                begin
                    $error("tdata pad: exp %h got %h", exp_b.axes >> (9*CW),
                           m_axis_tdata >> (9*CW));
                    errors++;
                end
                if (m_axis_tuser !== exp_b.degen)
                begin
                    $error("degenerate: exp %b got %b", exp_b.degen, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (rst_n && stim_done && pending_req.size() == 0 && !s_axis_tvalid);
        wait (expected_basis.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_basis.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $error("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
